FILE: rtl/aesc_pkg.sv
// aesc_pkg: shared types and constants for the accelerometer step counter.
// No dependencies; used by every module under rtl/.
package aesc_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int SCORE_W   = 16;
	localparam int BSTEPS_W  = 8;
	localparam int TOTAL_W   = 16;
	localparam int CFG_IDX_W = 2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVER_THRESHOLD = 2'd1;

	localparam logic signed [SCORE_W-1:0] THRESHOLD_RST      = 16'sh0000;
	localparam logic signed [SCORE_W-1:0] OVER_THRESHOLD_RST = 16'sh7fff;

	// first batch positions with a valid window energy / score
	localparam int ENERGY_START = 5;
	localparam int SCORE_START  = 6;

	typedef struct packed {
		logic first;   // position 0 of the batch
		logic last;    // final position of the batch
	} aesc_pos_t;

endpackage

FILE: rtl/accel_energy_step_counter_top.sv
// accel_energy_step_counter_top: step counter top level with input stage,
// config registers and handshake. Depends on aesc_pkg, aesc_score, aesc_peak.
//
// Usage:
//   sample channel: one signed 16-bit accelerometer sample per beat, taken
//   when sample_valid is high and sample_stall is low. BATCH_LEN samples
//   form a batch.
//   result channel: one beat per batch, carrying batch_steps and
//   total_steps, taken when result_valid is high and result_stall is low.
//   config channel: cfg_index selects threshold (0) or over_threshold (1);
//   cfg_ready is always high. Write only while the block is idle.
// Throughput: one sample per cycle while sample_stall is low. A sample
// sits in the input register; the whole square/energy/score/peak update
// runs from that register and loads the result register on a batch's last sample.
// Stall: a held result blocks only the last sample of the next batch; the
// input register then holds and sample_stall rises until the beat leaves.
// Reset: batch position, peak state and total clear; thresholds return to
// 0 and 32767. No result is pending after reset.
module accel_energy_step_counter_top #(
	parameter int BATCH_LEN = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic signed [aesc_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [aesc_pkg::BSTEPS_W-1:0]         batch_steps,
	output logic [aesc_pkg::TOTAL_W-1:0]          total_steps,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [aesc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [aesc_pkg::SCORE_W-1:0]          cfg_data
);

	logic                                 valid_s1;
	logic signed [aesc_pkg::SAMPLE_W-1:0] sample_s1;
	logic signed [aesc_pkg::SCORE_W-1:0]  threshold_q;
	logic signed [aesc_pkg::SCORE_W-1:0]  over_threshold_q;

	aesc_pkg::aesc_pos_t                  pos;
	logic signed [aesc_pkg::SCORE_W-1:0]  score;
	logic                                 fire;
	logic                                 take;

	// the last sample of a batch needs a free result register
	assign fire         = valid_s1 && (!pos.last || !result_valid || !result_stall);
	assign sample_stall = valid_s1 && !fire;
	assign take         = sample_valid && !sample_stall;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q      <= aesc_pkg::THRESHOLD_RST;
			over_threshold_q <= aesc_pkg::OVER_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				aesc_pkg::CFG_THRESHOLD: begin
					threshold_q <= $signed(cfg_data);
				end
				aesc_pkg::CFG_OVER_THRESHOLD: begin
					over_threshold_q <= $signed(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	aesc_score #(
		.BATCH_LEN (BATCH_LEN)
	) u_score (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (fire),
		.sample  (sample_s1),
		.pos     (pos),
		.score   (score)
	);

	aesc_peak u_peak (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (fire),
		.pos            (pos),
		.score          (score),
		.threshold      (threshold_q),
		.over_threshold (over_threshold_q),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.batch_steps    (batch_steps),
		.total_steps    (total_steps)
	);

endmodule

FILE: rtl/aesc_score.sv
// aesc_score: batch position counter, squared difference, window energy
// and peak score for one sample per cycle while advance is high. Depends on aesc_pkg.
module aesc_score #(
	parameter int BATCH_LEN = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 advance,
	input  logic signed [aesc_pkg::SAMPLE_W-1:0] sample,
	output aesc_pkg::aesc_pos_t                  pos,
	output logic signed [aesc_pkg::SCORE_W-1:0]  score
);

	localparam int POS_W = $clog2(BATCH_LEN);
	localparam int W     = aesc_pkg::SCORE_W;

	// Only the low 16 bits of the score survive, so squares and energies
	// are carried modulo 2^16.
	logic [POS_W-1:0] pos_q;
	logic [aesc_pkg::SAMPLE_W-1:0] prev_q;
	logic [W-1:0] sq_q [3];
	logic [W-1:0] en_q [4];

	logic [W-1:0] diff;
	logic [W-1:0] prod;
	logic [W-1:0] sq;
	logic [W-1:0] energy;
	logic [W-1:0] raw_score;

	assign pos.first = (pos_q == '0);
	assign pos.last  = (pos_q == POS_W'(BATCH_LEN - 1));

	assign diff = sample - prev_q;
	assign prod = diff * diff;
	assign sq   = pos.first ? '0 : prod;

	assign energy = (pos_q >= POS_W'(aesc_pkg::ENERGY_START))
		? (sq_q[0] + sq_q[1] + sq_q[2] + sq) : '0;

	assign raw_score = en_q[3] - en_q[0] + {en_q[1][W-2:0], 1'b0} + {energy[W-2:0], 1'b0};
	assign score = (pos_q >= POS_W'(aesc_pkg::SCORE_START)) ? $signed(raw_score) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (advance) begin
			pos_q <= pos.last ? '0 : pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prev_q  <= sample;
			sq_q[0] <= sq_q[1];
			sq_q[1] <= sq_q[2];
			sq_q[2] <= sq;
			en_q[0] <= en_q[1];
			en_q[1] <= en_q[2];
			en_q[2] <= en_q[3];
			en_q[3] <= energy;
		end
	end

endmodule

FILE: rtl/aesc_peak.sv
// aesc_peak: hysteresis peak counter, batch/total step counts and the
// result register. Depends on aesc_pkg.
module aesc_peak (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 advance,
	input  aesc_pkg::aesc_pos_t                  pos,
	input  logic signed [aesc_pkg::SCORE_W-1:0]  score,
	input  logic signed [aesc_pkg::SCORE_W-1:0]  threshold,
	input  logic signed [aesc_pkg::SCORE_W-1:0]  over_threshold,
	input  logic                                 result_stall,
	output logic                                 result_valid,
	output logic [aesc_pkg::BSTEPS_W-1:0]        batch_steps,
	output logic [aesc_pkg::TOTAL_W-1:0]         total_steps
);

	localparam int BW = aesc_pkg::BSTEPS_W;
	localparam int TW = aesc_pkg::TOTAL_W;

	logic          armed_q;
	logic [BW-1:0] count_q;
	logic [TW-1:0] total_q;
	logic          out_valid_q;
	logic [BW-1:0] batch_steps_q;
	logic [TW-1:0] total_steps_q;

	logic          armed_cur;
	logic [BW-1:0] count_cur;
	logic          hit;
	logic          armed_nx;
	logic [BW-1:0] count_nx;
	logic [TW-1:0] total_nx;

	// a new batch restarts the flag and count before this sample is judged
	assign armed_cur = pos.first ? 1'b0 : armed_q;
	assign count_cur = pos.first ? '0 : count_q;

	assign hit      = (score > threshold) && (score < over_threshold) && !armed_cur;
	assign count_nx = count_cur + BW'(hit);
	assign armed_nx = hit ? 1'b1 : ((score < threshold) ? 1'b0 : armed_cur);
	assign total_nx = total_q + TW'(count_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				armed_q <= armed_nx;
				count_q <= count_nx;
				if (pos.last) begin
					total_q <= total_nx;
				end
			end
			if (advance && pos.last) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pos.last) begin
			batch_steps_q <= count_nx;
			total_steps_q <= total_nx;
		end
	end

	assign result_valid = out_valid_q;
	assign batch_steps  = batch_steps_q;
	assign total_steps  = total_steps_q;

endmodule
